@@ rtl/ppm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_pkg: shared definitions for the priority pixel mixer
// Operation codes, resistor DAC weights and the structs between the stages.
// ----------------------------------------------------------------------------
package ppm_pkg;

	localparam logic [2:0] OP_PIXEL    = 3'd0;
	localparam logic [2:0] OP_WR_PRI   = 3'd1;
	localparam logic [2:0] OP_WR_PAL   = 3'd2;
	localparam logic [2:0] OP_WR_COL   = 3'd3;
	localparam logic [2:0] OP_CLR_COLL = 3'd4;
	localparam logic [2:0] OP_RD_COLL  = 3'd5;

	// Colour PROM spans three 256-entry planes; addresses at or above this are dropped.
	localparam logic [10:0] COL_PROM_DEPTH = 11'd768;

	localparam logic [7:0] DAC_W0 = 8'h0e;
	localparam logic [7:0] DAC_W1 = 8'h1f;
	localparam logic [7:0] DAC_W2 = 8'h43;
	localparam logic [7:0] DAC_W3 = 8'h8f;

	typedef struct packed {
		logic [2:0]  op;
		logic [8:0]  sprite_pixel;
		logic [10:0] fore_pixel;
		logic [10:0] back_pixel;
		logic [10:0] table_addr;
		logic [7:0]  table_data;
		logic        blank;
	} ppm_item_t;

	typedef struct packed {
		logic        we;
		logic [10:0] addr;
		logic [7:0]  data;
	} ppm_pal_wr_t;

	typedef struct packed {
		logic       valid;
		logic       pix_on;
		logic       hit;
		logic       cbit;
		logic       summ;
		logic       col_we;
		logic [9:0] col_addr;
		logic [3:0] col_data;
	} ppm_s2_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       collided;
		logic       collision_bit;
		logic       any_collision;
	} ppm_result_t;

	// Sum of the resistor weights selected by the four PROM bits; never exceeds 255.
	function automatic logic [7:0] dac_level(input logic [3:0] v);
		logic [7:0] acc;
		acc = 8'd0;
		if (v[0]) acc = acc + DAC_W0;
		if (v[1]) acc = acc + DAC_W1;
		if (v[2]) acc = acc + DAC_W2;
		if (v[3]) acc = acc + DAC_W3;
		return acc;
	endfunction

endpackage

@@ rtl/ppm_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_if: item and result channels of the pixel mixer
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ppm_item_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [8:0]  sprite_pixel;
	logic [10:0] fore_pixel;
	logic [10:0] back_pixel;
	logic [10:0] table_addr;
	logic [7:0]  table_data;

	modport source (
		output valid, op, sprite_pixel, fore_pixel, back_pixel, table_addr, table_data,
		input  ready
	);
	modport sink (
		input  valid, op, sprite_pixel, fore_pixel, back_pixel, table_addr, table_data,
		output ready
	);
endinterface

interface ppm_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       collided;
	logic       collision_bit;
	logic       any_collision;

	modport source (
		output valid, red, green, blue, collided, collision_bit, any_collision,
		input  ready
	);
	modport sink (
		input  valid, red, green, blue, collided, collision_bit, any_collision,
		output ready
	);
endinterface

@@ rtl/ppm_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_front: priority table lookup and collision map
// Stage 1 reads the priority table; stage 2 marks collisions and picks the layer.
// ----------------------------------------------------------------------------
module ppm_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 accept,
	input  ppm_pkg::ppm_item_t   item,
	output logic [10:0]          pal_rd_addr,
	output ppm_pkg::ppm_pal_wr_t pal_wr,
	output ppm_pkg::ppm_s2_t     s2
);

	logic [7:0]         pri_mem [128];
	logic [6:0]         pri_idx;
	logic               v_s1;
	ppm_pkg::ppm_item_t item_s1;
	logic [7:0]         lv_s1;

	logic [63:0]        coll_map_q;
	logic               summ_q;
	logic               pix;
	logic               hit;
	logic               clr;
	logic               summ_next;
	logic               cbit;
	logic [5:0]         coll_idx;

	assign pri_idx = {item.back_pixel[10:9], (item.back_pixel[2:0] == 3'd0),
	                  item.fore_pixel[10:9], (item.fore_pixel[2:0] == 3'd0),
	                  (item.sprite_pixel[3:0] == 4'd0)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
		end
	end

	// Table writes and lookups share stage 1, so program order is kept without forwarding.
	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= item;
			lv_s1   <= pri_mem[pri_idx];
		end
		if (accept && item.op == ppm_pkg::OP_WR_PRI) begin
			pri_mem[item.table_addr[6:0]] <= item.table_data;
		end
	end

	always_comb begin
		pix       = v_s1 && item_s1.op == ppm_pkg::OP_PIXEL && !item_s1.blank;
		hit       = pix && !lv_s1[2];
		clr       = v_s1 && item_s1.op == ppm_pkg::OP_CLR_COLL;
		coll_idx  = {lv_s1[3], item_s1.sprite_pixel[8:4]};
		summ_next = clr ? 1'b0 : (hit ? 1'b1 : summ_q);
		cbit      = v_s1 && item_s1.op == ppm_pkg::OP_RD_COLL &&
		            coll_map_q[item_s1.table_addr[5:0]];
		unique case (lv_s1[1:0])
			2'd0: begin
				pal_rd_addr = {2'b00, item_s1.sprite_pixel};
			end
			2'd1: begin
				pal_rd_addr = {2'b01, item_s1.fore_pixel[8:0]};
			end
			default: begin
				pal_rd_addr = {2'b10, item_s1.back_pixel[8:0]};
			end
		endcase
		pal_wr.we   = en && v_s1 && item_s1.op == ppm_pkg::OP_WR_PAL;
		pal_wr.addr = item_s1.table_addr;
		pal_wr.data = item_s1.table_data;
	end

	// The collision map is a 64-bit vector; reset and a clear both empty it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coll_map_q <= '0;
			summ_q     <= 1'b0;
			s2         <= '0;
		end else if (en) begin
			if (clr) begin
				coll_map_q <= '0;
			end else if (hit) begin
				coll_map_q[coll_idx] <= 1'b1;
			end
			summ_q      <= summ_next;
			s2.valid    <= v_s1;
			s2.pix_on   <= pix;
			s2.hit      <= hit;
			s2.cbit     <= cbit;
			s2.summ     <= summ_next;
			s2.col_we   <= v_s1 && item_s1.op == ppm_pkg::OP_WR_COL &&
			               item_s1.table_addr < ppm_pkg::COL_PROM_DEPTH;
			s2.col_addr <= item_s1.table_addr[9:0];
			s2.col_data <= item_s1.table_data[3:0];
		end
	end

`ifndef NO_ASSERTIONS
	a_hit_sets_summary: assert property (@(posedge clk) disable iff (!arst_n)
		en && hit |=> summ_q && coll_map_q[$past(coll_idx)])
		else $error("collision hit did not set map entry and summary");
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		en && clr |=> !summ_q && coll_map_q == 64'd0)
		else $error("collision clear left marks behind");
	a_summary_covers_map: assert property (@(posedge clk) disable iff (!arst_n)
		coll_map_q != 64'd0 |-> summ_q)
		else $error("collision mark present without summary flag");
`endif

endmodule

@@ rtl/ppm_palette.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_palette: palette RAM
// 2048 x 8 synchronous RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ppm_palette (
	input  logic                 clk,
	input  logic                 en,
	input  logic [10:0]          rd_addr,
	input  ppm_pkg::ppm_pal_wr_t wr,
	output logic [7:0]           rd_data
);

	logic [7:0] pal_mem [2048];

	always_ff @(posedge clk) begin
		if (en) begin
			rd_data <= pal_mem[rd_addr];
		end
		if (wr.we) begin
			pal_mem[wr.addr] <= wr.data;
		end
	end

endmodule

@@ rtl/ppm_colour.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_colour: colour PROM planes, resistor DAC and result register
// Stage 3 reads the red, green and blue planes; stage 4 holds the result beat.
// ----------------------------------------------------------------------------
module ppm_colour (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  ppm_pkg::ppm_s2_t     s2,
	input  logic [7:0]           ci,
	output ppm_pkg::ppm_result_t res
);

	logic [3:0] red_mem [256];
	logic [3:0] grn_mem [256];
	logic [3:0] blu_mem [256];

	logic       v_s3;
	logic       pix_s3;
	logic       hit_s3;
	logic       cbit_s3;
	logic       summ_s3;
	logic [3:0] red_s3;
	logic [3:0] grn_s3;
	logic [3:0] blu_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			res  <= '0;
		end else if (en) begin
			v_s3              <= s2.valid;
			res.valid         <= v_s3;
			res.red           <= pix_s3 ? ppm_pkg::dac_level(red_s3) : 8'd0;
			res.green         <= pix_s3 ? ppm_pkg::dac_level(grn_s3) : 8'd0;
			res.blue          <= pix_s3 ? ppm_pkg::dac_level(blu_s3) : 8'd0;
			res.collided      <= hit_s3;
			res.collision_bit <= cbit_s3;
			res.any_collision <= summ_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s3  <= s2.pix_on;
			hit_s3  <= s2.hit;
			cbit_s3 <= s2.cbit;
			summ_s3 <= s2.summ;
			red_s3  <= red_mem[ci];
			grn_s3  <= grn_mem[ci];
			blu_s3  <= blu_mem[ci];
		end
		if (en && s2.col_we) begin
			unique case (s2.col_addr[9:8])
				2'd0: begin
					red_mem[s2.col_addr[7:0]] <= s2.col_data;
				end
				2'd1: begin
					grn_mem[s2.col_addr[7:0]] <= s2.col_data;
				end
				default: begin
					blu_mem[s2.col_addr[7:0]] <= s2.col_data;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_dark_unless_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		en && !pix_s3 |=> res.red == 8'd0 && res.green == 8'd0 && res.blue == 8'd0)
		else $error("colour driven for a beat that is not a shown pixel");
	a_hit_needs_summary: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s3 && hit_s3 |=> res.any_collision)
		else $error("collided result without summary flag");
`endif

endmodule

@@ rtl/priority_pixel_mixer_palette_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_pixel_mixer_palette_unit: per-pixel layer mixer with palette DAC
// Mixes sprite, foreground and background pixels through a priority table,
// marks sprite collisions, and converts the palette colour to RGB.
// ----------------------------------------------------------------------------
//
// Channel    Modport  Beat contents
// items      sink     op, sprite/fore/back pixels, table address and data
// results    source   red, green, blue, collided, collision_bit, any_collision
// cfg_wr_*   -        blank_screen register, written when cfg_wr_en is high
//
// One item is accepted every cycle while the pipeline moves; each item
// yields exactly one result beat. The four stages are the priority table
// read, the palette RAM read, the colour PROM read and the result register.
// When a result waits and results.ready is low, the whole pipeline holds and
// items.ready drops in the same cycle. Reset empties the pipeline, clears the
// collision map, the summary flag and blank_screen; the tables need writes.
//
// Each table is written in the same stage that reads it, so a write followed
// by a pixel sees the new contents without any forwarding path.
module priority_pixel_mixer_palette_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic         cfg_wr_data,
	ppm_item_if.sink     items,
	ppm_result_if.source results
);

	logic                 blank_q;
	logic                 en;
	logic                 accept;
	ppm_pkg::ppm_item_t   item;
	logic [10:0]          pal_rd_addr;
	ppm_pkg::ppm_pal_wr_t pal_wr;
	ppm_pkg::ppm_s2_t     s2;
	logic [7:0]           ci;
	ppm_pkg::ppm_result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_q <= 1'b0;
		end else if (cfg_wr_en) begin
			blank_q <= cfg_wr_data;
		end
	end

	// The pipeline moves whenever the result register is empty or being drained.
	assign en          = !res.valid || results.ready;
	assign items.ready = en;
	assign accept      = items.valid && en;

	always_comb begin
		item.op           = items.op;
		item.sprite_pixel = items.sprite_pixel;
		item.fore_pixel   = items.fore_pixel;
		item.back_pixel   = items.back_pixel;
		item.table_addr   = items.table_addr;
		item.table_data   = items.table_data;
		item.blank        = blank_q;
	end

	ppm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.accept      (accept),
		.item        (item),
		.pal_rd_addr (pal_rd_addr),
		.pal_wr      (pal_wr),
		.s2          (s2)
	);

	ppm_palette u_palette (
		.clk     (clk),
		.en      (en),
		.rd_addr (pal_rd_addr),
		.wr      (pal_wr),
		.rd_data (ci)
	);

	ppm_colour u_colour (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.s2     (s2),
		.ci     (ci),
		.res    (res)
	);

	assign results.valid         = res.valid;
	assign results.red           = res.red;
	assign results.green         = res.green;
	assign results.blue          = res.blue;
	assign results.collided      = res.collided;
	assign results.collision_bit = res.collision_bit;
	assign results.any_collision = res.any_collision;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the priority pixel mixer
// Sends pixel, table-load and collision-map beats through the item channel,
// predicts every result beat from a private copy of the tables, and compares
// each returned beat field by field while both channels idle and stall.
// ----------------------------------------------------------------------------
module tb;

	// The two op codes the block leaves unused; they must change nothing.
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;

	// Generous ceiling. The slowest legal run, with every beat waiting out the
	// longest gap on both sides, stays far below this.
	localparam int LIMIT_CYCLES = 1000000;
	// Length of the long receiver hold-off that backs up the pipeline.
	localparam int LONG_HOLD = 300;
	// Cycles allowed after the last expected beat to catch stray results.
	localparam int TAIL_CYCLES = 12;

	// How eagerly a side moves beats: no idling, occasional idling, or a
	// random wait before every beat.
	typedef enum int {PACE_FULL, PACE_LIGHT, PACE_HEAVY} pace_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [8:0]  spr;
		logic [10:0] fg;
		logic [10:0] bg;
		logic [10:0] addr;
		logic [7:0]  data;
	} mix_beat_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       collided;
		logic       cbit;
		logic       any;
	} mix_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_wr_data;

	ppm_item_if   mix_in ();
	ppm_result_if mix_out ();

	priority_pixel_mixer_palette_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.items      (mix_in),
		.results    (mix_out)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Predicted contents of the block. These change only when the monitor
	// sees a beat accepted or set_blank runs, so they mirror the block.
	// ------------------------------------------------------------------
	logic [7:0]  pri_tbl  [128];
	logic [7:0]  pal_mem  [2048];
	logic [3:0]  col_prom [768];
	logic [63:0] coll_map;
	logic        coll_any;
	logic        blank_now;

	// Entries that the queued stimulus has already written. The stimulus side
	// uses these to load a table entry before any pixel can read it, since the
	// tables come out of reset with undefined contents.
	bit pri_seen  [128];
	bit pal_seen  [2048];
	bit prom_seen [768];

	mix_beat_t   pending_beats [$];
	mix_result_t mixed_expect [$];

	// Handshake bookkeeping. Each counter has exactly one writer.
	int    tx_sent;         // driver: beats put on the item channel
	int    tx_taken;        // monitor: item beats accepted
	int    tx_gap;          // driver: idle cycles before the next beat
	int    results_taken;   // monitor: result beats accepted
	int    rx_seen;         // receiver: last result count it reacted to
	int    rx_wait;         // receiver: cycles left before raising ready
	int    hold_requests;   // stimulus: long hold-offs asked for
	int    holds_served;    // receiver: long hold-offs started
	int    long_hold;       // receiver: cycles left in the current hold-off
	pace_t tx_pace;
	pace_t rx_pace;
	int    err_count;
	int    cycle_count;

	mix_beat_t   drv_beat;
	mix_beat_t   mon_beat;
	mix_result_t mon_want;

	// Resistor DAC: each set PROM bit adds its weight to the 8-bit level.
	function automatic logic [7:0] dac_out(input logic [3:0] v);
		return (v[0] ? ppm_pkg::DAC_W0 : 8'd0) + (v[1] ? ppm_pkg::DAC_W1 : 8'd0) +
			(v[2] ? ppm_pkg::DAC_W2 : 8'd0) + (v[3] ? ppm_pkg::DAC_W3 : 8'd0);
	endfunction

	// Priority table index: transparency flags and priorities of the layers.
	function automatic logic [6:0] pri_index(input mix_beat_t b);
		return {b.bg[10:9], b.bg[2:0] == 3'd0, b.fg[10:9], b.fg[2:0] == 3'd0,
			b.spr[3:0] == 4'd0};
	endfunction

	// Applies one accepted beat to the predicted state and returns the result
	// beat the block must produce for it.
	function automatic mix_result_t mix_and_update(input mix_beat_t b);
		mix_result_t r;
		logic [7:0]  lv;
		logic [10:0] pal;
		logic [7:0]  ci;
		r = '0;
		case (b.op)
			ppm_pkg::OP_PIXEL: begin
				// A blanked pixel reads nothing and marks nothing.
				if (!blank_now) begin
					lv = pri_tbl[pri_index(b)];
					if (!lv[2]) begin
						coll_map[{lv[3], b.spr[8:4]}] = 1'b1;
						coll_any = 1'b1;
						r.collided = 1'b1;
					end
					case (lv[1:0])
						2'd0: pal = {2'b00, b.spr};
						2'd1: pal = {2'b01, b.fg[8:0]};
						default: pal = {2'b10, b.bg[8:0]};
					endcase
					ci = pal_mem[pal];
					r.red = dac_out(col_prom[{2'b00, ci}]);
					r.green = dac_out(col_prom[{2'b01, ci}]);
					r.blue = dac_out(col_prom[{2'b10, ci}]);
				end
			end
			ppm_pkg::OP_WR_PRI: pri_tbl[b.addr[6:0]] = b.data;
			ppm_pkg::OP_WR_PAL: pal_mem[b.addr] = b.data;
			ppm_pkg::OP_WR_COL: begin
				// Only the low nibble is kept; addresses past the PROM are dropped.
				if (b.addr < ppm_pkg::COL_PROM_DEPTH)
					col_prom[b.addr[9:0]] = b.data[3:0];
			end
			ppm_pkg::OP_CLR_COLL: begin
				coll_map = '0;
				coll_any = 1'b0;
			end
			ppm_pkg::OP_RD_COLL: r.cbit = coll_map[b.addr[5:0]];
			default: ;
		endcase
		r.any = coll_any;
		return r;
	endfunction

	function automatic int draw_wait(input pace_t p);
		case (p)
			PACE_FULL: return 0;
			PACE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
			default: return $urandom_range(0, 17);
		endcase
	endfunction

	function automatic mix_beat_t beat_of(input logic [2:0] op, input logic [8:0] spr,
			input logic [10:0] fg, input logic [10:0] bg, input logic [10:0] addr,
			input logic [7:0] data);
		mix_beat_t b;
		b = '{op: op, spr: spr, fg: fg, bg: bg, addr: addr, data: data};
		return b;
	endfunction

	// Random beat over every op. Pixels get transparent pens more often than
	// plain chance would give, so all transparency combinations show up.
	function automatic mix_beat_t random_beat();
		mix_beat_t b;
		int pick;
		pick = $urandom_range(0, 99);
		b.spr = 9'($urandom);
		b.fg = 11'($urandom);
		b.bg = 11'($urandom);
		b.addr = 11'($urandom);
		b.data = 8'($urandom);
		if (pick < 55)
			b.op = ppm_pkg::OP_PIXEL;
		else if (pick < 63)
			b.op = ppm_pkg::OP_WR_PRI;
		else if (pick < 71)
			b.op = ppm_pkg::OP_WR_PAL;
		else if (pick < 79)
			b.op = ppm_pkg::OP_WR_COL;
		else if (pick < 82)
			b.op = ppm_pkg::OP_CLR_COLL;
		else if (pick < 94)
			b.op = ppm_pkg::OP_RD_COLL;
		else if (pick < 97)
			b.op = OP_SPARE6;
		else
			b.op = OP_SPARE7;
		if (b.op == ppm_pkg::OP_PIXEL) begin
			if ($urandom_range(0, 3) == 0) b.spr[3:0] = '0;
			if ($urandom_range(0, 3) == 0) b.fg[2:0] = '0;
			if ($urandom_range(0, 3) == 0) b.bg[2:0] = '0;
		end
		return b;
	endfunction

	task automatic queue_raw(input mix_beat_t b);
		case (b.op)
			ppm_pkg::OP_WR_PRI: pri_seen[b.addr[6:0]] = 1'b1;
			ppm_pkg::OP_WR_PAL: pal_seen[b.addr] = 1'b1;
			ppm_pkg::OP_WR_COL: if (b.addr < ppm_pkg::COL_PROM_DEPTH) prom_seen[b.addr] = 1'b1;
			default: ;
		endcase
		pending_beats.push_back(b);
	endtask

	// A palette byte selects one entry in each of the three PROM planes, so
	// those entries are loaded first if they were never written.
	task automatic queue_pal_write(input mix_beat_t b);
		mix_beat_t f;
		for (int p = 0; p < 3; p++) begin
			if (!prom_seen[p * 256 + b.data]) begin
				f = b;
				f.op = ppm_pkg::OP_WR_COL;
				f.addr = 11'(p * 256 + b.data);
				f.data = 8'($urandom);
				queue_raw(f);
			end
		end
		queue_raw(b);
	endtask

	// Queues a beat, preceded by whatever table loads keep a pixel from ever
	// reading an entry that was never written.
	task automatic queue_beat(input mix_beat_t b);
		mix_beat_t f;
		logic [6:0] idx;
		if (b.op == ppm_pkg::OP_PIXEL) begin
			idx = pri_index(b);
			if (!pri_seen[idx]) begin
				f = random_beat();
				f.op = ppm_pkg::OP_WR_PRI;
				f.addr = {f.addr[10:7], idx};
				queue_raw(f);
			end
			for (int layer = 0; layer < 3; layer++) begin
				f = random_beat();
				f.op = ppm_pkg::OP_WR_PAL;
				case (layer)
					0: f.addr = {2'b00, b.spr};
					1: f.addr = {2'b01, b.fg[8:0]};
					default: f.addr = {2'b10, b.bg[8:0]};
				endcase
				if (!pal_seen[f.addr])
					queue_pal_write(f);
			end
			queue_raw(b);
		end else if (b.op == ppm_pkg::OP_WR_PAL) begin
			queue_pal_write(b);
		end else begin
			queue_raw(b);
		end
	endtask

	task automatic note_mismatch(input string msg);
		err_count++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input int n, input int got,
			input int want);
		if (got != want)
			note_mismatch($sformatf("result %0d %s got %0h want %0h", n, name, got, want));
	endtask

	// Block is idle: nothing queued, nothing on the wire, nothing in flight.
	task automatic wait_idle();
		while (pending_beats.size() != 0 || tx_sent != tx_taken || mixed_expect.size() != 0)
			@(negedge clk);
	endtask

	// The register may only change while the block is idle. Every item yields
	// a result, so once the last expected beat is back the pipeline is empty.
	task automatic set_blank(input logic v);
		wait_idle();
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = v;
		@(posedge clk);
		blank_now = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic run_random(input int n, input pace_t tx, input pace_t rx);
		@(posedge clk);
		tx_pace = tx;
		rx_pace = rx;
		for (int i = 0; i < n; i++)
			queue_beat(random_beat());
		while (pending_beats.size() != 0)
			@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Driver. Changes the item channel at the falling edge only. A beat stays
	// on the wire until the monitor has counted it as accepted; then the
	// driver waits its drawn gap and offers the next one.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (tx_sent != tx_taken) begin
				// Beat still waiting for ready: hold everything.
			end else if (tx_gap > 0) begin
				tx_gap--;
				mix_in.valid <= 1'b0;
			end else if (pending_beats.size() != 0) begin
				drv_beat = pending_beats.pop_front();
				mix_in.valid <= 1'b1;
				mix_in.op <= drv_beat.op;
				mix_in.sprite_pixel <= drv_beat.spr;
				mix_in.fore_pixel <= drv_beat.fg;
				mix_in.back_pixel <= drv_beat.bg;
				mix_in.table_addr <= drv_beat.addr;
				mix_in.table_data <= drv_beat.data;
				tx_sent++;
				tx_gap = draw_wait(tx_pace);
			end else begin
				mix_in.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver. Draws a wait after each accepted result beat and, when asked,
	// holds ready low for a long stretch so the block backs up and has to
	// drop its own item ready.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_requests != holds_served) begin
				holds_served = hold_requests;
				long_hold = LONG_HOLD;
			end
			if (results_taken != rx_seen) begin
				rx_seen = results_taken;
				rx_wait = draw_wait(rx_pace);
			end
			if (long_hold > 0) begin
				long_hold--;
				mix_out.ready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				mix_out.ready <= 1'b0;
			end else begin
				mix_out.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor. Samples both channels at the rising edge. Results are checked
	// before the item of the same edge is predicted; with a multi-stage
	// pipeline they never belong to the same beat anyway.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (mix_out.valid && mix_out.ready) begin
				if (mixed_expect.size() == 0) begin
					note_mismatch($sformatf("result %0d arrived with nothing expected",
						results_taken));
				end else begin
					mon_want = mixed_expect.pop_front();
					check_field("red", results_taken, mix_out.red, mon_want.red);
					check_field("green", results_taken, mix_out.green, mon_want.green);
					check_field("blue", results_taken, mix_out.blue, mon_want.blue);
					check_field("collided", results_taken, mix_out.collided,
						mon_want.collided);
					check_field("collision_bit", results_taken, mix_out.collision_bit,
						mon_want.cbit);
					check_field("any_collision", results_taken, mix_out.any_collision,
						mon_want.any);
				end
				results_taken++;
			end
			if (mix_in.valid && mix_in.ready) begin
				mon_beat = beat_of(mix_in.op, mix_in.sprite_pixel, mix_in.fore_pixel,
					mix_in.back_pixel, mix_in.table_addr, mix_in.table_data);
				mixed_expect.push_back(mix_and_update(mon_beat));
				tx_taken++;
			end
		end
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus sequence and end of run.
	// ------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		mix_in.valid = 1'b0;
		mix_in.op = ppm_pkg::OP_PIXEL;
		mix_in.sprite_pixel = '0;
		mix_in.fore_pixel = '0;
		mix_in.back_pixel = '0;
		mix_in.table_addr = '0;
		mix_in.table_data = '0;
		mix_out.ready = 1'b0;
		coll_map = '0;
		coll_any = 1'b0;
		blank_now = 1'b0;
		tx_sent = 0;
		tx_taken = 0;
		tx_gap = 0;
		results_taken = 0;
		rx_seen = 0;
		rx_wait = 0;
		hold_requests = 0;
		holds_served = 0;
		long_hold = 0;
		tx_pace = PACE_LIGHT;
		rx_pace = PACE_LIGHT;
		err_count = 0;
		cycle_count = 0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_blank(1'b0);

		// Directed part: table extremes and every special case.
		@(posedge clk);
		// Priority address wraps at 128: 2047 lands on entry 127.
		queue_beat(beat_of(ppm_pkg::OP_WR_PRI, 9'd0, 11'd0, 11'd0, 11'h7ff, 8'h00));
		// Entry 0x13 (all layers transparent) via a wrapped address: collision
		// in the upper bank, foreground layer chosen.
		queue_beat(beat_of(ppm_pkg::OP_WR_PRI, 9'd0, 11'd0, 11'd0, 11'h093, 8'h09));
		queue_beat(beat_of(ppm_pkg::OP_WR_COL, 9'd0, 11'd0, 11'd0, 11'd767, 8'hff));
		// PROM writes at or beyond the end are dropped.
		queue_beat(beat_of(ppm_pkg::OP_WR_COL, 9'd0, 11'd0, 11'd0, 11'd768, 8'h05));
		queue_beat(beat_of(ppm_pkg::OP_WR_COL, 9'd0, 11'd0, 11'd0, 11'h7ff, 8'haa));
		queue_beat(beat_of(ppm_pkg::OP_WR_PAL, 9'd0, 11'd0, 11'd0, 11'h7ff, 8'hff));
		queue_beat(beat_of(ppm_pkg::OP_WR_PAL, 9'd0, 11'd0, 11'd0, 11'h000, 8'h00));
		queue_beat(beat_of(ppm_pkg::OP_PIXEL, 9'd0, 11'd0, 11'd0, 11'd0, 8'd0));
		queue_beat(beat_of(ppm_pkg::OP_PIXEL, 9'h1ff, 11'h7ff, 11'h7ff, 11'h7ff, 8'hff));
		queue_beat(beat_of(ppm_pkg::OP_PIXEL, 9'h1f0, 11'h7f8, 11'h000, 11'h000, 8'h00));
		queue_beat(beat_of(ppm_pkg::OP_PIXEL, 9'h00f, 11'h207, 11'h5f8, 11'h400, 8'h80));
		// Collision reads wrap at 64.
		queue_beat(beat_of(ppm_pkg::OP_RD_COLL, 9'd0, 11'd0, 11'd0, 11'h7ff, 8'd0));
		queue_beat(beat_of(ppm_pkg::OP_RD_COLL, 9'd0, 11'd0, 11'd0, 11'h060, 8'd0));
		queue_beat(beat_of(ppm_pkg::OP_RD_COLL, 9'd0, 11'd0, 11'd0, 11'd32, 8'd0));
		queue_beat(beat_of(OP_SPARE6, 9'h1ff, 11'h7ff, 11'h7ff, 11'h7ff, 8'hff));
		queue_beat(beat_of(OP_SPARE7, 9'd0, 11'd0, 11'd0, 11'd0, 8'd0));
		queue_beat(beat_of(ppm_pkg::OP_CLR_COLL, 9'h1ff, 11'h7ff, 11'h7ff, 11'h7ff, 8'hff));
		queue_beat(beat_of(ppm_pkg::OP_RD_COLL, 9'd0, 11'd0, 11'd0, 11'd32, 8'd0));
		queue_beat(beat_of(ppm_pkg::OP_PIXEL, 9'h1ff, 11'h7ff, 11'h7ff, 11'h7ff, 8'hff));

		// Blanked screen: the all-transparent pixel would mark a collision if
		// it were mixed, so the read after it shows that nothing was marked.
		set_blank(1'b1);
		@(posedge clk);
		queue_beat(beat_of(ppm_pkg::OP_CLR_COLL, 9'd0, 11'd0, 11'd0, 11'd0, 8'd0));
		queue_beat(beat_of(ppm_pkg::OP_PIXEL, 9'd0, 11'd0, 11'd0, 11'd0, 8'd0));
		queue_beat(beat_of(ppm_pkg::OP_RD_COLL, 9'd0, 11'd0, 11'd0, 11'd32, 8'd0));
		run_random(30, PACE_LIGHT, PACE_LIGHT);
		set_blank(1'b0);

		// Random part with the pacing of both sides varied between stretches.
		// Each random pixel also pulls in the table loads it depends on.
		run_random(60, PACE_FULL, PACE_FULL);
		run_random(60, PACE_LIGHT, PACE_LIGHT);
		run_random(60, PACE_HEAVY, PACE_FULL);
		run_random(60, PACE_FULL, PACE_HEAVY);

		set_blank(1'b1);
		run_random(20, PACE_HEAVY, PACE_HEAVY);
		set_blank(1'b0);

		// Back-pressure: the receiver stops for a long stretch while the
		// sender keeps offering beats, so the pipeline fills and stalls.
		@(posedge clk);
		hold_requests++;
		run_random(40, PACE_FULL, PACE_FULL);

		run_random(50, PACE_LIGHT, PACE_HEAVY);

		wait_idle();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (err_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/ppm_pkg.sv
rtl/ppm_if.sv
rtl/ppm_front.sv
rtl/ppm_palette.sv
rtl/ppm_colour.sv
rtl/priority_pixel_mixer_palette_unit.sv
bench/tb.sv
